// ===== rtl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the two-heap running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int CNT_W    = 11;

  // heap select: lower half is a max-heap, upper half a min-heap
  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch sample, decide path
    OP_SD_INIT,  // start sift-down at the top of the pass-through heap
    OP_SD_RDL,   // read left child
    OP_SD_RDR,   // capture left child, read right child
    OP_SD_STEP,  // move best child up or settle value
    OP_SD_FIN,   // settle value at a leaf
    OP_PU_INIT,  // start sift-up at the tail of the receiving heap
    OP_PU_RDP,   // read parent
    OP_PU_STEP,  // move parent down or settle value
    OP_PU_FIN,   // settle value at the root
    OP_OUT       // load result register
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;       // store full, request is dropped
    logic swap;       // sample displaces the top of the pass-through heap
    logic l_lt_n;     // left child exists
    logic down_move;  // sift-down continues
    logic i_zero;     // sift-up reached the root
    logic up_move;    // sift-up continues
    logic out_free;   // result register can take a new result
  } stat_t;

endpackage

// ===== rtl/rmth_dp.sv =====
// ----------------------------------------------------------------------------
// rmth_dp
// Datapath: shared heap memory, sift registers, heap sizes, cached tops and
// the result register.
// ----------------------------------------------------------------------------
module rmth_dp import rmth_pkg::*; #(
  parameter int HEAP_DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [MED_W-1:0]    out_median_doubled,
  output logic [CNT_W-1:0]           out_sample_count,
  output logic                       out_dropped
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_V = SW'(HEAP_DEPTH);

  // both heaps in one memory, heap select as the top address bit
  logic signed [SAMPLE_W-1:0] mem [2**(AW+1)];
  logic signed [SAMPLE_W-1:0] rdata_r;

  logic [SW-1:0]              lsz_r, usz_r, n_r;
  logic signed [SAMPLE_W-1:0] ltop_r, utop_r, s_r, k_r, v_r, cl_r;
  logic [AW-1:0]              i_r;
  logic                       sel_r, even_r, full_r, swap_r;
  logic                       out_valid_r, dropped_r;
  logic signed [MED_W-1:0]    med_r;
  logic [CNT_W-1:0]           cnt_r;

  logic                       we_c, re_c;
  logic [AW:0]                waddr_c, raddr_c;
  logic signed [SAMPLE_W-1:0] wdata_c;
  logic [AW-1:0]              i_nxt;

  logic [AW:0]                l_idx;
  logic [AW+1:0]              r_idx;
  logic [AW-1:0]              p_idx;
  logic                       is_max, r_lt_n, take_r, down_move, up_move;
  logic signed [SAMPLE_W-1:0] best_v;
  logic [AW-1:0]              best_i;
  logic                       in_even, in_swap;

  function automatic logic above(input logic signed [SAMPLE_W-1:0] a,
                                 input logic signed [SAMPLE_W-1:0] b,
                                 input logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  // child and parent indices of the current hole
  assign is_max = (sel_r == SEL_LOWER);
  assign l_idx  = {i_r, 1'b1};
  assign r_idx  = {({1'b0, i_r} + (AW+1)'(1)), 1'b0};
  assign p_idx  = (i_r - AW'(1)) >> 1;
  assign r_lt_n = r_idx < {1'b0, n_r};

  // pick the better child, then compare against the held value
  assign take_r    = r_lt_n && above(rdata_r, cl_r, is_max);
  assign best_v    = take_r ? rdata_r : cl_r;
  assign best_i    = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign down_move = above(best_v, v_r, is_max);
  assign up_move   = above(v_r, rdata_r, is_max);

  // decide path for an arriving request
  assign in_even = (lsz_r == usz_r);
  assign in_swap = in_even ? ((usz_r != '0) && (in_sample > utop_r))
                           : (in_sample < ltop_r);

  assign stat.full      = full_r;
  assign stat.swap      = swap_r;
  assign stat.l_lt_n    = l_idx < n_r;
  assign stat.down_move = down_move;
  assign stat.i_zero    = (i_r == '0);
  assign stat.up_move   = up_move;
  assign stat.out_free  = !out_valid_r || out_ready;

  // memory access per command
  always_comb begin
    we_c    = 1'b0;
    re_c    = 1'b0;
    waddr_c = {sel_r, i_r};
    raddr_c = {sel_r, l_idx[AW-1:0]};
    wdata_c = v_r;
    i_nxt   = i_r;
    case (cmd.op)
      OP_SD_RDL: begin
        re_c = 1'b1;
      end
      OP_SD_RDR: begin
        re_c    = 1'b1;
        raddr_c = {sel_r, r_idx[AW-1:0]};
      end
      OP_SD_STEP: begin
        we_c = 1'b1;
        if (down_move) begin
          wdata_c = best_v;
          i_nxt   = best_i;
        end
      end
      OP_SD_FIN, OP_PU_FIN: begin
        we_c = 1'b1;
      end
      OP_PU_RDP: begin
        re_c    = 1'b1;
        raddr_c = {sel_r, p_idx};
      end
      OP_PU_STEP: begin
        we_c = 1'b1;
        if (up_move) begin
          wdata_c = rdata_r;
          i_nxt   = p_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    if (re_c) begin
      rdata_r <= mem[raddr_c];
    end
  end

  // sift registers and cached tops
  always_ff @(posedge clk) begin
    if (we_c && (waddr_c[AW-1:0] == '0)) begin
      if (sel_r == SEL_LOWER) begin
        ltop_r <= wdata_c;
      end else begin
        utop_r <= wdata_c;
      end
    end
    case (cmd.op)
      OP_LOAD: begin
        s_r    <= in_sample;
        even_r <= in_even;
        full_r <= (lsz_r == DEPTH_V) && (usz_r == DEPTH_V);
        swap_r <= in_swap;
        k_r    <= in_swap ? (in_even ? utop_r : ltop_r) : in_sample;
      end
      OP_SD_INIT: begin
        sel_r <= even_r ? SEL_UPPER : SEL_LOWER;
        v_r   <= s_r;
        i_r   <= '0;
        n_r   <= even_r ? usz_r : lsz_r;
      end
      OP_SD_RDR: begin
        cl_r <= rdata_r;
      end
      OP_SD_STEP, OP_PU_STEP: begin
        i_r <= i_nxt;
      end
      OP_PU_INIT: begin
        sel_r <= even_r ? SEL_LOWER : SEL_UPPER;
        v_r   <= k_r;
        i_r   <= even_r ? lsz_r[AW-1:0] : usz_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // heap sizes and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsz_r       <= '0;
      usz_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_PU_INIT) begin
        if (even_r) begin
          lsz_r <= lsz_r + SW'(1);
        end else begin
          usz_r <= usz_r + SW'(1);
        end
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      med_r     <= (lsz_r == usz_r)
                   ? (MED_W'(ltop_r) + MED_W'(utop_r))
                   : {ltop_r, 1'b0};
      cnt_r     <= CNT_W'({1'b0, lsz_r} + {1'b0, usz_r});
      dropped_r <= full_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_sample_count   = cnt_r;
  assign out_dropped        = dropped_r;

endmodule

// ===== rtl/rmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmth_ctrl
// Controller: sequences load, sift-down, sift-up and result per request.
// ----------------------------------------------------------------------------
module rmth_ctrl import rmth_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEL, ST_SDL, ST_SDR, ST_SDC, ST_PUI, ST_PUP, ST_PUC, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (stat.full) begin
          state_nxt = ST_OUT;
        end else if (stat.swap) begin
          cmd.op    = OP_SD_INIT;
          state_nxt = ST_SDL;
        end else begin
          state_nxt = ST_PUI;
        end
      end
      ST_SDL: begin
        if (stat.l_lt_n) begin
          cmd.op    = OP_SD_RDL;
          state_nxt = ST_SDR;
        end else begin
          cmd.op    = OP_SD_FIN;
          state_nxt = ST_PUI;
        end
      end
      ST_SDR: begin
        cmd.op    = OP_SD_RDR;
        state_nxt = ST_SDC;
      end
      ST_SDC: begin
        cmd.op    = OP_SD_STEP;
        state_nxt = stat.down_move ? ST_SDL : ST_PUI;
      end
      ST_PUI: begin
        cmd.op    = OP_PU_INIT;
        state_nxt = ST_PUP;
      end
      ST_PUP: begin
        if (stat.i_zero) begin
          cmd.op    = OP_PU_FIN;
          state_nxt = ST_OUT;
        end else begin
          cmd.op    = OP_PU_RDP;
          state_nxt = ST_PUC;
        end
      end
      ST_PUC: begin
        cmd.op    = OP_PU_STEP;
        state_nxt = stat.up_move ? ST_PUP : ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/running_median_two_heaps_top.sv =====
// Each request runs load, an optional sift-down of the pass-through heap, a sift-up
// into the receiving heap and the result; a full store goes straight to the result.
// Throughput: one request at a time, set by the heap memory walk.
// Reset: synchronous active-low rst_n empties both heaps; memory is not cleared.
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median over all samples so far, kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top import rmth_pkg::*; #(
  parameter int HEAP_DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [MED_W-1:0]    out_median_doubled,
  output logic [CNT_W-1:0]           out_sample_count,
  output logic                       out_dropped
);

  cmd_t  cmd;
  stat_t stat;

  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmth_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample          (in_sample),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_median_doubled (out_median_doubled),
    .out_sample_count   (out_sample_count),
    .out_dropped        (out_dropped)
  );

endmodule

// ===== sim/running_median_two_heaps_top_tb.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_top_tb
// Drives signed samples into the two-heap running median block, predicts the
// doubled median, count and drop flag of every request with a two-heap model
// of its own, and checks each result in order. The run fills the store past
// capacity, so drops are exercised too.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top_tb;
  import rmth_pkg::*;

  localparam int DEPTH      = 512;
  localparam int N_RANDOM   = 1630;
  localparam int QUIET_FROM = 1450;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic signed [MED_W-1:0] median_doubled;
    logic [CNT_W-1:0]        sample_count;
    logic                    dropped;
  } median_result_t;

  // two-heap median predictor and in-order result checker
  class median_scoreboard;
    logic signed [SAMPLE_W-1:0] heap [2][DEPTH];
    int unsigned                fill [2];
    median_result_t             pending_q[$];
    int                         errors;

    function new();
      fill[SEL_LOWER] = 0;
      fill[SEL_UPPER] = 0;
      errors = 0;
    endfunction

    // true if a ranks above b: lower heap is max-first, upper heap min-first
    function bit ranks_above(logic sel, logic signed [SAMPLE_W-1:0] a,
                             logic signed [SAMPLE_W-1:0] b);
      return (sel == SEL_LOWER) ? (a > b) : (a < b);
    endfunction

    function void heap_insert(logic sel, logic signed [SAMPLE_W-1:0] v);
      int unsigned i, p;
      logic signed [SAMPLE_W-1:0] t;
      i = fill[sel];
      if (i >= DEPTH) return;
      heap[sel][i] = v;
      fill[sel]++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!ranks_above(sel, heap[sel][i], heap[sel][p])) break;
        t = heap[sel][i]; heap[sel][i] = heap[sel][p]; heap[sel][p] = t;
        i = p;
      end
    endfunction

    // overwrite the root with v and sift it down
    function void heap_swap_root(logic sel, logic signed [SAMPLE_W-1:0] v);
      int unsigned i, l, r, best;
      logic signed [SAMPLE_W-1:0] t;
      i = 0;
      heap[sel][0] = v;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        best = i;
        if (l < fill[sel] && ranks_above(sel, heap[sel][l], heap[sel][best])) best = l;
        if (r < fill[sel] && ranks_above(sel, heap[sel][r], heap[sel][best])) best = r;
        if (best == i) break;
        t = heap[sel][i]; heap[sel][i] = heap[sel][best]; heap[sel][best] = t;
        i = best;
      end
    endfunction

    // accepted request: update the heaps and queue the expected result
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      median_result_t r;
      logic signed [SAMPLE_W-1:0] k;
      logic signed [SAMPLE_W-1:0] lo_top, hi_top;
      r.dropped = 1'b0;
      k = s;
      if (fill[SEL_LOWER] >= DEPTH && fill[SEL_UPPER] >= DEPTH) begin
        r.dropped = 1'b1;
      end else if (fill[SEL_LOWER] == fill[SEL_UPPER]) begin
        if (fill[SEL_UPPER] > 0 && s > heap[SEL_UPPER][0]) begin
          k = heap[SEL_UPPER][0];
          heap_swap_root(SEL_UPPER, s);
        end
        heap_insert(SEL_LOWER, k);
      end else begin
        if (fill[SEL_LOWER] > 0 && s < heap[SEL_LOWER][0]) begin
          k = heap[SEL_LOWER][0];
          heap_swap_root(SEL_LOWER, s);
        end
        heap_insert(SEL_UPPER, k);
      end
      lo_top = heap[SEL_LOWER][0];
      hi_top = heap[SEL_UPPER][0];
      if (fill[SEL_LOWER] == fill[SEL_UPPER])
        r.median_doubled = {lo_top[SAMPLE_W-1], lo_top} + {hi_top[SAMPLE_W-1], hi_top};
      else
        r.median_doubled = {lo_top, 1'b0};
      r.sample_count = CNT_W'(fill[SEL_LOWER] + fill[SEL_UPPER]);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [MED_W-1:0] med, logic [CNT_W-1:0] cnt,
                               logic drp);
      median_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: median_doubled=%0d", med);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (med !== e.median_doubled) begin
        $error("median_doubled: expected %0d, got %0d", e.median_doubled, med);
        errors++;
      end
      if (cnt !== e.sample_count) begin
        $error("sample_count: expected %0d, got %0d", e.sample_count, cnt);
        errors++;
      end
      if (drp !== e.dropped) begin
        $error("dropped: expected %0b, got %0b", e.dropped, drp);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [MED_W-1:0]    out_median_doubled;
  logic [CNT_W-1:0]           out_sample_count;
  logic                       out_dropped;

  median_scoreboard sb = new();
  int  accepted;
  bit  quiet;

  running_median_two_heaps_top #(.HEAP_DEPTH(DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_median_doubled (out_median_doubled),
    .out_sample_count   (out_sample_count),
    .out_dropped        (out_dropped)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one request and hold it until accepted; returns at the next falling edge
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    in_valid  = 1'b1;
    in_sample = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
    accepted++;
    @(negedge clk);
  endtask

  // drop valid for a random burst, now and then
  task automatic sender_gap();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 19);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      6:          return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      7:          return SAMPLE_W'($signed($urandom_range(0, 2000)) - 1000);
      8:          return 32'sh7fffff00 + SAMPLE_W'($urandom_range(0, 255));
      default:    return 32'sh80000000 + SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int  idle;
    bit  held;
    idle = 0;
    held = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && accepted >= HOLD_AT) begin
        held = 1;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (idle > 0) begin
        idle--;
        out_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle = $urandom_range(1, 19) - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // check results on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_median_doubled, out_sample_count, out_dropped);
  end

  initial begin
    #20_000_000;
    $display("running_median_two_heaps_top_tb: errors");
    $finish;
  end

  initial begin
    logic signed [SAMPLE_W-1:0] directed [$];
    int wait_cycles;
    accepted  = 0;
    quiet     = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes, overflow-prone sums, equal values, sign boundaries
    directed = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, -1, 1,
                 -1, 1, 5, 5, 5, 5, 32'sh7fffffff, 32'sh80000000, 3, -3, 2, 2};
    foreach (directed[i]) begin
      send_sample(directed[i]);
      sender_gap();
    end

    // random samples; the store fills and later requests are dropped
    for (int i = 0; i < N_RANDOM; i++) begin
      if (accepted >= QUIET_FROM) quiet = 1;
      send_sample(pick_sample());
      sender_gap();
    end
    in_valid = 1'b0;

    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("running_median_two_heaps_top_tb: clean");
    end else begin
      if (sb.pending_q.size() != 0)
        $error("%0d expected results never arrived", sb.pending_q.size());
      $display("running_median_two_heaps_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rmth_pkg.sv
rtl/rmth_dp.sv
rtl/rmth_ctrl.sv
rtl/running_median_two_heaps_top.sv
sim/running_median_two_heaps_top_tb.sv
